[hdl/round_robin_thread_scheduler_unit_macros.svh]
// Assertion macros for the round robin thread scheduler.
// No dependencies; taken in by the files that carry assertions.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_UNIT_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication
`define RRTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/rrts_pkg.sv]
// Shared types and constants of the round robin thread scheduler.
// No dependencies.
package rrts_pkg;
	localparam int THREAD_COUNT_DEF = 32;
	localparam logic [31:0] TICK_RESET = 32'd10000;
	localparam int MS_TO_US = 1000;

	typedef enum logic [1:0] {
		ST_READY = 2'd0,
		ST_RUNNING = 2'd1,
		ST_WAITING = 2'd2,
		ST_TERM = 2'd3
	} thr_state_t;

	typedef enum logic [2:0] {
		CMD_TICK = 3'd0,
		CMD_CREATE = 3'd1,
		CMD_TERM = 3'd2,
		CMD_SLEEP = 3'd3,
		CMD_WAITC = 3'd4,
		CMD_CHAR = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK = 2'd0,
		STAT_NO_SLOT = 2'd1,
		STAT_CW_BUSY = 2'd2,
		STAT_IGNORED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_LT,
		ALU_LE
	} alu_op_t;

	typedef struct packed {
		alu_op_t op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;
endpackage

[hdl/rrts_mem.sv]
// Single-port-write, single-port-read memory with registered read data.
// No dependencies.
module rrts_mem #(
	parameter int W = 8,
	parameter int D = 32
) (
	input logic clk,
	input logic we,
	input logic [$clog2(D)-1:0] waddr,
	input logic [W-1:0] wdata,
	input logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hdl/rrts_alu.sv]
// Shared 32-bit add, subtract and compare unit of the scheduler.
// Depends on rrts_pkg.
module rrts_alu (
	input rrts_pkg::alu_req_t req,
	output logic [31:0] res,
	output logic flag
);
	import rrts_pkg::*;

	logic [31:0] x;
	logic [31:0] y;
	logic sub;
	logic [32:0] sum;

	always_comb begin
		x = req.a;
		y = req.b;
		sub = 1'b1;
		unique case (req.op)
			ALU_ADD: sub = 1'b0;
			ALU_LE: begin
				// a <= b as b - a without borrow
				x = req.b;
				y = req.a;
			end
			default: sub = 1'b1;
		endcase
		sum = {1'b0, x} + {1'b0, (sub ? ~y : y)} + {32'd0, sub};
		res = sum[31:0];
		flag = (req.op == ALU_LT) ? !sum[32] : sum[32];
	end
endmodule

[hdl/round_robin_thread_scheduler_unit.sv]
// Round robin thread scheduler: sequencer over the thread tables and one shared ALU.
// Depends on rrts_pkg, rrts_mem, rrts_alu and the assertion macro header.
//
// Channel | Signals                                              | Direction
// input   | in_valid, in_stall, command, now_us, sleep_millis,   | item in
//         | reschedule                                           |
// output  | out_valid, out_stall, status, idle, running_thread,  | item out
//         | created_thread, timer_us                             |
// config  | cfg_valid, cfg_ready, cfg_data                       | tick interval
//
// How long an item takes is set by the sleep-list walks (a step per sleeper, plus a
// run-list insert per woken thread) and the free-slot scan (a step per slot), which
// run through the registered table reads.
// in_stall is high from acceptance until the result is loaded into the output register.
// A finished result waits in that register while the next item is accepted.
// Reset clears the thread states to terminated and empties head, sleep list and waiter.
module round_robin_thread_scheduler_unit #(
	parameter int THREAD_COUNT = rrts_pkg::THREAD_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] command,
	input logic [31:0] now_us,
	input logic [22:0] sleep_millis,
	input logic reschedule,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] status,
	output logic idle,
	output logic [4:0] running_thread,
	output logic [4:0] created_thread,
	output logic [31:0] timer_us,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [31:0] cfg_data
);
	import rrts_pkg::*;

	`include "round_robin_thread_scheduler_unit_macros.svh"

	localparam int IW = $clog2(THREAD_COUNT);
	localparam int SW = $clog2(THREAD_COUNT + 1);
	localparam logic [SW-1:0] STEP_MAX = SW'(THREAD_COUNT);
	localparam logic [IW-1:0] LAST_IDX = IW'(THREAD_COUNT - 1);

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_CR_RD, S_CR_CHK, S_CR_POST, S_SLP_MUL, S_SLP_ADD, S_CHR,
		S_RM_RD, S_RM_WR, S_INS_A, S_INS_B, S_INS_C, S_WK_INIT, S_WK_CHK, S_WK_RD,
		S_SC_ISS, S_SC_RD, S_SC_RUN, S_TM_START, S_TM_FIRST, S_TM_CHK, S_TM_RD,
		S_TM_SUB, S_DONE
	} state_t;

	state_t state_q, ret_q;

	logic [2:0] cmd_q;
	logic [31:0] now_q;
	logic [22:0] millis_q;
	logic resched_q;
	logic [31:0] tick_q;
	logic [IW-1:0] head_q, sleep_head_q, cw_q, tgt_q, idx_q, cur_q, prior_q, after_q;
	logic head_ok_q, sleep_ok_q, cw_ok_q, cur_ok_q, prior_ok_q, have_shown_q;
	logic [SW-1:0] steps_q;
	logic [31:0] prod_q, soonest_q, timer_q;
	logic [1:0] status_q;
	logic [IW-1:0] created_q;
	logic out_valid_q, out_idle_q;
	logic [1:0] out_status_q;
	logic [4:0] out_run_q, out_created_q;
	logic [31:0] out_timer_q;

	// table ports
	logic st_we, rn_we, rp_we, sn_we, wt_we;
	logic [IW-1:0] st_wa, rn_wa, rp_wa, sn_wa, wt_wa;
	logic [IW-1:0] st_ra, rn_ra, rp_ra, sn_ra, wt_ra;
	logic [1:0] st_wd, st_rd;
	logic [IW-1:0] rn_wd, rn_rd, rp_wd, rp_rd;
	logic [IW:0] sn_wd, sn_rd;
	logic [31:0] wt_wd, wt_rd;
	logic [THREAD_COUNT-1:0] st_vld_q;
	logic st_vld_rd_q;
	thr_state_t st_val;

	alu_req_t alu_req;
	logic [31:0] alu_res;
	logic alu_flag;

	logic in_acc;
	logic out_free;
	logic [IW-1:0] nxt;
	logic nxt_ok;
	logic [6:0] shown_w;
	logic [6:0] created_w;

	rrts_mem #(.W(2), .D(THREAD_COUNT)) u_st (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd)
	);
	rrts_mem #(.W(IW), .D(THREAD_COUNT)) u_rn (
		.clk(clk), .we(rn_we), .waddr(rn_wa), .wdata(rn_wd), .raddr(rn_ra), .rdata(rn_rd)
	);
	rrts_mem #(.W(IW), .D(THREAD_COUNT)) u_rp (
		.clk(clk), .we(rp_we), .waddr(rp_wa), .wdata(rp_wd), .raddr(rp_ra), .rdata(rp_rd)
	);
	rrts_mem #(.W(IW + 1), .D(THREAD_COUNT)) u_sn (
		.clk(clk), .we(sn_we), .waddr(sn_wa), .wdata(sn_wd), .raddr(sn_ra), .rdata(sn_rd)
	);
	rrts_mem #(.W(32), .D(THREAD_COUNT)) u_wt (
		.clk(clk), .we(wt_we), .waddr(wt_wa), .wdata(wt_wd), .raddr(wt_ra), .rdata(wt_rd)
	);

	rrts_alu u_alu (.req(alu_req), .res(alu_res), .flag(alu_flag));

	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;
	assign nxt = sn_rd[IW-1:0];
	assign nxt_ok = sn_rd[IW];
	assign st_val = st_vld_rd_q ? thr_state_t'(st_rd) : ST_TERM;

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign idle = out_idle_q;
	assign running_thread = out_run_q;
	assign created_thread = out_created_q;
	assign timer_us = out_timer_q;

	assign shown_w = have_shown_q ? 7'(tgt_q) : (head_ok_q ? 7'(head_q) : 7'd0);
	assign created_w = 7'(created_q);

	// never-written states read as terminated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_vld_q <= '0;
			st_vld_rd_q <= 1'b0;
		end else begin
			if (st_we) begin
				st_vld_q[st_wa] <= 1'b1;
			end
			st_vld_rd_q <= st_vld_q[st_ra];
		end
	end

	always_comb begin
		st_ra = '0;
		rn_ra = '0;
		rp_ra = '0;
		sn_ra = '0;
		wt_ra = '0;
		unique case (state_q) inside
			S_CR_RD: st_ra = idx_q;
			S_RM_RD: begin
				rn_ra = tgt_q;
				rp_ra = tgt_q;
			end
			S_WK_CHK, S_TM_CHK: begin
				sn_ra = cur_q;
				wt_ra = cur_q;
			end
			S_INS_A: rn_ra = head_q;
			S_SC_ISS: begin
				rn_ra = head_q;
				st_ra = head_q;
			end
			S_TM_START: begin
				sn_ra = sleep_head_q;
				wt_ra = sleep_head_q;
			end
			default: st_ra = '0;
		endcase
	end

	always_comb begin
		st_we = 1'b0;
		st_wa = '0;
		st_wd = ST_READY;
		rn_we = 1'b0;
		rn_wa = '0;
		rn_wd = '0;
		rp_we = 1'b0;
		rp_wa = '0;
		rp_wd = '0;
		sn_we = 1'b0;
		sn_wa = '0;
		sn_wd = '0;
		wt_we = 1'b0;
		wt_wa = '0;
		wt_wd = '0;
		alu_req.op = ALU_ADD;
		alu_req.a = '0;
		alu_req.b = '0;
		unique case (state_q)
			S_DISP: begin
				st_wa = head_q;
				case (cmd_q)
					CMD_TERM: begin
						st_we = head_ok_q;
						st_wd = ST_TERM;
					end
					CMD_WAITC: begin
						st_we = !cw_ok_q && head_ok_q;
						st_wd = ST_WAITING;
					end
					CMD_CHAR: begin
						st_we = cw_ok_q && head_ok_q;
						st_wd = ST_READY;
					end
					default: st_we = 1'b0;
				endcase
			end
			S_CR_CHK: begin
				st_we = (st_val == ST_TERM);
				st_wa = idx_q;
				st_wd = ST_READY;
			end
			S_SLP_ADD: begin
				alu_req.op = ALU_ADD;
				alu_req.a = now_q;
				alu_req.b = prod_q;
				wt_we = 1'b1;
				wt_wa = tgt_q;
				wt_wd = alu_res;
				st_we = 1'b1;
				st_wa = tgt_q;
				st_wd = ST_WAITING;
				sn_we = 1'b1;
				sn_wa = tgt_q;
				sn_wd = {sleep_ok_q, sleep_head_q};
			end
			S_CHR: begin
				st_we = 1'b1;
				st_wa = tgt_q;
				st_wd = ST_RUNNING;
			end
			S_RM_WR: begin
				rn_we = (rp_rd != tgt_q);
				rn_wa = rp_rd;
				rn_wd = rn_rd;
				rp_we = (rp_rd != tgt_q);
				rp_wa = rn_rd;
				rp_wd = rp_rd;
			end
			S_WK_RD: begin
				alu_req.op = ALU_LE;
				alu_req.a = wt_rd;
				alu_req.b = now_q;
				sn_we = alu_flag && prior_ok_q;
				sn_wa = prior_q;
				sn_wd = sn_rd;
				st_we = alu_flag;
				st_wa = cur_q;
				st_wd = ST_READY;
			end
			S_INS_A: begin
				rn_we = !head_ok_q;
				rn_wa = tgt_q;
				rn_wd = tgt_q;
				rp_we = !head_ok_q;
				rp_wa = tgt_q;
				rp_wd = tgt_q;
			end
			S_INS_B: begin
				rp_we = 1'b1;
				rp_wa = tgt_q;
				rp_wd = head_q;
				rn_we = 1'b1;
				rn_wa = tgt_q;
				rn_wd = rn_rd;
			end
			S_INS_C: begin
				rp_we = 1'b1;
				rp_wa = after_q;
				rp_wd = tgt_q;
				rn_we = 1'b1;
				rn_wa = head_q;
				rn_wd = tgt_q;
			end
			S_SC_RD: begin
				st_we = ((rn_rd != head_q) || (st_val == ST_READY)) && (st_val == ST_RUNNING);
				st_wa = head_q;
				st_wd = ST_READY;
			end
			S_SC_RUN: begin
				st_we = 1'b1;
				st_wa = head_q;
				st_wd = ST_RUNNING;
			end
			S_TM_RD: begin
				alu_req.op = ALU_LT;
				alu_req.a = wt_rd;
				alu_req.b = soonest_q;
			end
			S_TM_SUB: begin
				alu_req.op = ALU_SUB;
				alu_req.a = soonest_q;
				alu_req.b = now_q;
			end
			default: st_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			cmd_q <= '0;
			now_q <= '0;
			millis_q <= '0;
			resched_q <= 1'b0;
			tick_q <= TICK_RESET;
			head_q <= '0;
			head_ok_q <= 1'b0;
			sleep_head_q <= '0;
			sleep_ok_q <= 1'b0;
			cw_q <= '0;
			cw_ok_q <= 1'b0;
			tgt_q <= '0;
			idx_q <= '0;
			cur_q <= '0;
			cur_ok_q <= 1'b0;
			prior_q <= '0;
			prior_ok_q <= 1'b0;
			after_q <= '0;
			steps_q <= '0;
			prod_q <= '0;
			soonest_q <= '0;
			timer_q <= '0;
			status_q <= STAT_OK;
			created_q <= '0;
			have_shown_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_status_q <= '0;
			out_idle_q <= 1'b0;
			out_run_q <= '0;
			out_created_q <= '0;
			out_timer_q <= '0;
		end else begin
			if (cfg_valid) begin
				tick_q <= cfg_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cmd_q <= command;
						now_q <= now_us;
						millis_q <= sleep_millis;
						resched_q <= reschedule;
						status_q <= STAT_OK;
						created_q <= '0;
						timer_q <= '0;
						have_shown_q <= 1'b0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					unique case (cmd_q)
						CMD_TICK: state_q <= S_WK_INIT;
						CMD_CREATE: begin
							idx_q <= '0;
							state_q <= S_CR_RD;
						end
						CMD_TERM: begin
							tgt_q <= head_q;
							if (!head_ok_q) begin
								status_q <= STAT_IGNORED;
								state_q <= S_DONE;
							end else begin
								state_q <= S_RM_RD;
							end
						end
						CMD_SLEEP: begin
							tgt_q <= head_q;
							if (millis_q == '0) begin
								state_q <= S_DONE;
							end else if (!head_ok_q) begin
								status_q <= STAT_IGNORED;
								state_q <= S_DONE;
							end else begin
								state_q <= S_SLP_MUL;
							end
						end
						CMD_WAITC: begin
							tgt_q <= head_q;
							if (cw_ok_q) begin
								status_q <= STAT_CW_BUSY;
								state_q <= S_DONE;
							end else if (!head_ok_q) begin
								status_q <= STAT_IGNORED;
								state_q <= S_DONE;
							end else begin
								cw_q <= head_q;
								cw_ok_q <= 1'b1;
								state_q <= S_RM_RD;
							end
						end
						CMD_CHAR: begin
							tgt_q <= cw_q;
							if (!cw_ok_q) begin
								status_q <= STAT_IGNORED;
								state_q <= S_DONE;
							end else begin
								state_q <= S_CHR;
							end
						end
						default: begin
							status_q <= STAT_IGNORED;
							state_q <= S_DONE;
						end
					endcase
				end
				S_CR_RD: state_q <= S_CR_CHK;
				S_CR_CHK: begin
					if (st_val == ST_TERM) begin
						created_q <= idx_q;
						tgt_q <= idx_q;
						ret_q <= S_CR_POST;
						state_q <= S_INS_A;
					end else if (idx_q == LAST_IDX) begin
						status_q <= STAT_NO_SLOT;
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_CR_RD;
					end
				end
				S_CR_POST: state_q <= resched_q ? S_WK_INIT : S_DONE;
				S_SLP_MUL: begin
					prod_q <= 32'({9'd0, millis_q} * 32'(MS_TO_US));
					state_q <= S_SLP_ADD;
				end
				S_SLP_ADD: begin
					// push onto the sleep list, then unlink from the run list
					sleep_head_q <= tgt_q;
					sleep_ok_q <= 1'b1;
					state_q <= S_RM_RD;
				end
				S_CHR: begin
					have_shown_q <= 1'b1;
					cw_ok_q <= 1'b0;
					ret_q <= S_TM_START;
					state_q <= S_INS_A;
				end
				S_RM_RD: state_q <= S_RM_WR;
				S_RM_WR: begin
					if (rp_rd == tgt_q) begin
						head_ok_q <= 1'b0;
					end
					state_q <= S_WK_INIT;
				end
				S_INS_A: begin
					if (!head_ok_q) begin
						head_q <= tgt_q;
						head_ok_q <= 1'b1;
						state_q <= ret_q;
					end else begin
						state_q <= S_INS_B;
					end
				end
				S_INS_B: begin
					after_q <= rn_rd;
					state_q <= S_INS_C;
				end
				S_INS_C: state_q <= ret_q;
				S_WK_INIT: begin
					cur_q <= sleep_head_q;
					cur_ok_q <= sleep_ok_q;
					prior_ok_q <= 1'b0;
					steps_q <= '0;
					state_q <= S_WK_CHK;
				end
				S_WK_CHK: state_q <= (cur_ok_q && steps_q < STEP_MAX) ? S_WK_RD : S_SC_ISS;
				S_WK_RD: begin
					steps_q <= steps_q + 1'b1;
					cur_q <= nxt;
					cur_ok_q <= nxt_ok;
					if (alu_flag) begin
						if (!prior_ok_q) begin
							sleep_head_q <= nxt;
							sleep_ok_q <= nxt_ok;
						end
						tgt_q <= cur_q;
						ret_q <= S_WK_CHK;
						state_q <= S_INS_A;
					end else begin
						prior_q <= cur_q;
						prior_ok_q <= 1'b1;
						state_q <= S_WK_CHK;
					end
				end
				S_SC_ISS: state_q <= head_ok_q ? S_SC_RD : S_TM_START;
				S_SC_RD: begin
					if ((rn_rd != head_q) || (st_val == ST_READY)) begin
						head_q <= rn_rd;
						state_q <= S_SC_RUN;
					end else begin
						state_q <= S_TM_START;
					end
				end
				S_SC_RUN: state_q <= S_TM_START;
				S_TM_START: begin
					if (head_ok_q || !sleep_ok_q) begin
						timer_q <= tick_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_TM_FIRST;
					end
				end
				S_TM_FIRST: begin
					soonest_q <= wt_rd;
					cur_q <= nxt;
					cur_ok_q <= nxt_ok;
					steps_q <= SW'(1);
					state_q <= S_TM_CHK;
				end
				S_TM_CHK: state_q <= (cur_ok_q && steps_q < STEP_MAX) ? S_TM_RD : S_TM_SUB;
				S_TM_RD: begin
					if (alu_flag) begin
						soonest_q <= wt_rd;
					end
					cur_q <= nxt;
					cur_ok_q <= nxt_ok;
					steps_q <= steps_q + 1'b1;
					state_q <= S_TM_CHK;
				end
				S_TM_SUB: begin
					timer_q <= alu_res;
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_status_q <= status_q;
						out_idle_q <= !(have_shown_q || head_ok_q);
						out_run_q <= shown_w[4:0];
						out_created_q <= created_w[4:0];
						out_timer_q <= timer_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RRTS_ASSERT_NEXT(a_accept_starts, clk, arst_n, in_acc, state_q == S_DISP, "accepted item did not start the sequencer")
	`RRTS_ASSERT_NEXT(a_done_loads, clk, arst_n, (state_q == S_DONE) && out_free, out_valid_q && (state_q == S_IDLE), "finished result not loaded")
	`RRTS_ASSERT_NOW(a_idle_shows_zero, clk, arst_n, out_valid_q && out_idle_q, out_run_q == 5'd0, "idle result shows a thread")
	`RRTS_ASSERT_NOW(a_walk_bounded, clk, arst_n, 1'b1, steps_q <= STEP_MAX, "list walk ran past the table size")
endmodule
